### rtl/jtl_pkg.sv
// ============================================================================
// jtl_pkg: shared types and constants for the JSON token lexer
// Holds the request/response word types, token kind codes, byte codes and
// counter widths used by the lexer core, result buffer and top level.
// ============================================================================
`default_nettype none

package jtl_pkg;

   // Counter widths
   localparam int OFFSET_BITS = 32;
   localparam int LINE_BITS   = 24;

   localparam logic [LINE_BITS-1:0]   LINE_MAX   = {LINE_BITS{1'b1}};
   localparam logic [OFFSET_BITS-1:0] OFF_MAX    = {OFFSET_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0]   FIRST_LINE_RESET = LINE_BITS'(1);

   // Byte codes
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_VTAB      = 8'h0B;
   localparam logic [7:0] CHAR_FORMFEED  = 8'h0C;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;

   // Token kinds
   typedef enum logic [3:0] {
      KIND_END      = 4'd0,
      KIND_LBRACE   = 4'd1,
      KIND_RBRACE   = 4'd2,
      KIND_LBRACKET = 4'd3,
      KIND_RBRACKET = 4'd4,
      KIND_COLON    = 4'd5,
      KIND_COMMA    = 4'd6,
      KIND_STRING   = 4'd7,
      KIND_BARE     = 4'd8
   } jtl_kind_type;

   // Input word
   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } jtl_req_type;

   // Output word
   typedef struct packed {
      logic [3:0]             token_kind;
      logic [LINE_BITS-1:0]   token_line;
      logic [OFFSET_BITS-1:0] token_column;
      logic [OFFSET_BITS-1:0] content_offset;
      logic [OFFSET_BITS-1:0] content_length;
      logic                   unterminated;
      logic                   last_of_run;
   } jtl_rsp_type;

   // Up to three results per input word
   localparam int MAX_RESULTS = 3;

   // Results of one input word, core to result buffer
   typedef struct packed {
      logic [1:0]                         count;
      jtl_rsp_type [MAX_RESULTS-1:0]      slot;
   } jtl_load_type;

endpackage

`default_nettype wire

### rtl/jtl_core.sv
// ============================================================================
// jtl_core: lexer state and per-byte token logic
// Holds the lexing mode and position counters, decodes one input word per
// firing cycle and produces up to three results for the result buffer.
// ============================================================================
`default_nettype none

module jtl_core
   import jtl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire jtl_req_type          item,
   input  wire logic                 csr_write_en,
   input  wire logic [LINE_BITS-1:0] csr_write_data,
   output jtl_load_type              load
);

   typedef enum logic [1:0] {
      MODE_BETWEEN = 2'd0,
      MODE_STRING  = 2'd1,
      MODE_BARE    = 2'd2
   } mode_type;

   // State registers
   mode_type               mode_ff,       mode_in;
   logic                   bslash_ff,     bslash_in;
   logic [LINE_BITS-1:0]   first_line_ff;
   logic [LINE_BITS-1:0]   line_ff,       line_in;
   logic [OFFSET_BITS-1:0] offset_ff,     offset_in;
   logic [OFFSET_BITS-1:0] column_ff,     column_in;   // column of the next byte
   logic [LINE_BITS-1:0]   start_line_ff, start_line_in;
   logic [OFFSET_BITS-1:0] start_col_ff,  start_col_in;
   logic [OFFSET_BITS-1:0] start_off_ff,  start_off_in;
   logic [OFFSET_BITS-1:0] length_ff,     length_in;

   logic       [7:0]        c;
   logic                    is_space;
   logic                    is_delim;
   logic                    newline_seen;
   logic [1:0]              cnt_v;
   jtl_rsp_type [MAX_RESULTS-1:0] slot_v;
   jtl_kind_type            punct_kind;
   logic                    is_punct;

   function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
      return (v == OFF_MAX) ? v : v + OFFSET_BITS'(1);
   endfunction

   function automatic logic [LINE_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] v);
      return (v == LINE_MAX) ? v : v + LINE_BITS'(1);
   endfunction

   function automatic jtl_rsp_type make_rsp(
      input jtl_kind_type           kind,
      input logic [LINE_BITS-1:0]   line,
      input logic [OFFSET_BITS-1:0] col,
      input logic [OFFSET_BITS-1:0] off,
      input logic [OFFSET_BITS-1:0] len,
      input logic                   unterm
   );
      jtl_rsp_type r;
      r.token_kind     = kind;
      r.token_line     = line;
      r.token_column   = col;
      r.content_offset = off;
      r.content_length = len;
      r.unterminated   = unterm;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   // Byte classes
   assign c        = item.data_byte;
   assign is_space = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NEWLINE) ||
                     (c == CHAR_VTAB) || (c == CHAR_FORMFEED) || (c == CHAR_CR);
   assign is_delim = is_space || (c == CHAR_COMMA) || (c == CHAR_RBRACE) ||
                     (c == CHAR_RBRACKET);

   always_comb begin
      unique case (c)
         CHAR_LBRACE:   punct_kind = KIND_LBRACE;
         CHAR_RBRACE:   punct_kind = KIND_RBRACE;
         CHAR_LBRACKET: punct_kind = KIND_LBRACKET;
         CHAR_RBRACKET: punct_kind = KIND_RBRACKET;
         CHAR_COLON:    punct_kind = KIND_COLON;
         CHAR_COMMA:    punct_kind = KIND_COMMA;
         default:       punct_kind = KIND_END;
      endcase
   end
   assign is_punct = (punct_kind != KIND_END);

   // Next state and results for the word in the input register
   always_comb begin
      logic do_between;
      mode_in       = mode_ff;
      bslash_in     = bslash_ff;
      line_in       = line_ff;
      offset_in     = offset_ff;
      column_in     = column_ff;
      start_line_in = start_line_ff;
      start_col_in  = start_col_ff;
      start_off_in  = start_off_ff;
      length_in     = length_ff;
      newline_seen  = 1'b0;
      do_between    = 1'b0;
      cnt_v         = 2'd0;
      slot_v        = '0;

      if (item.has_byte) begin
         unique case (mode_ff)
            MODE_STRING: begin
               if ((c == CHAR_QUOTE) && !bslash_ff) begin
                  slot_v[cnt_v] = make_rsp(KIND_STRING, start_line_ff, start_col_ff,
                                           start_off_ff, length_ff, 1'b0);
                  cnt_v   = cnt_v + 2'd1;
                  mode_in = MODE_BETWEEN;
               end else begin
                  length_in = sat_off(length_ff);
               end
               bslash_in = (c == CHAR_BACKSLASH);
            end
            MODE_BARE: begin
               if (is_delim) begin
                  slot_v[cnt_v] = make_rsp(KIND_BARE, start_line_ff, start_col_ff,
                                           start_off_ff, length_ff, 1'b0);
                  cnt_v      = cnt_v + 2'd1;
                  mode_in    = MODE_BETWEEN;
                  do_between = 1'b1;
               end else begin
                  length_in = sat_off(length_ff);
               end
            end
            default: begin
               mode_in    = MODE_BETWEEN;
               do_between = 1'b1;
            end
         endcase

         // Lexing between tokens
         if (do_between) begin
            if (is_space) begin
               if (c == CHAR_NEWLINE) begin
                  newline_seen = 1'b1;
                  line_in      = sat_line(line_ff);
               end
            end else if (is_punct) begin
               slot_v[cnt_v] = make_rsp(punct_kind, line_ff, column_ff, offset_ff,
                                        '0, 1'b0);
               cnt_v = cnt_v + 2'd1;
            end else begin
               start_line_in = line_ff;
               start_col_in  = column_ff;
               if (c == CHAR_QUOTE) begin
                  mode_in      = MODE_STRING;
                  bslash_in    = 1'b0;
                  start_off_in = sat_off(offset_ff);
                  length_in    = '0;
               end else begin
                  mode_in      = MODE_BARE;
                  start_off_in = offset_ff;
                  length_in    = OFFSET_BITS'(1);
               end
            end
         end

         // Position advance; a newline restarts the column
         offset_in = sat_off(offset_ff);
         if (newline_seen) begin
            column_in = OFFSET_BITS'(1);
         end else if (offset_ff != OFF_MAX) begin
            column_in = sat_off(column_ff);
         end
      end

      // End of buffer: flush, end token, restart
      if (item.end_of_buffer) begin
         if (mode_in == MODE_BARE) begin
            slot_v[cnt_v] = make_rsp(KIND_BARE, start_line_in, start_col_in,
                                     start_off_in, length_in, 1'b0);
            cnt_v = cnt_v + 2'd1;
         end else if (mode_in == MODE_STRING) begin
            slot_v[cnt_v] = make_rsp(KIND_STRING, start_line_in, start_col_in,
                                     start_off_in, '0, 1'b1);
            cnt_v = cnt_v + 2'd1;
         end
         slot_v[cnt_v] = make_rsp(KIND_END, line_in, column_in, offset_in, '0, 1'b0);
         cnt_v = cnt_v + 2'd1;

         mode_in       = MODE_BETWEEN;
         bslash_in     = 1'b0;
         line_in       = first_line_ff;
         offset_in     = '0;
         column_in     = OFFSET_BITS'(1);
         start_line_in = '0;
         start_col_in  = '0;
         start_off_in  = '0;
         length_in     = '0;
      end

      load.count = cnt_v;
      load.slot  = slot_v;
   end

   // State update; a register write reloads the line count before the first byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_BETWEEN;
         bslash_ff     <= 1'b0;
         first_line_ff <= FIRST_LINE_RESET;
         line_ff       <= FIRST_LINE_RESET;
         offset_ff     <= '0;
         column_ff     <= OFFSET_BITS'(1);
         start_line_ff <= '0;
         start_col_ff  <= '0;
         start_off_ff  <= '0;
         length_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            first_line_ff <= csr_write_data;
         end
         if (fire) begin
            mode_ff       <= mode_in;
            bslash_ff     <= bslash_in;
            line_ff       <= line_in;
            offset_ff     <= offset_in;
            column_ff     <= column_in;
            start_line_ff <= start_line_in;
            start_col_ff  <= start_col_in;
            start_off_ff  <= start_off_in;
            length_ff     <= length_in;
         end else if (csr_write_en && (offset_ff == '0) && (mode_ff == MODE_BETWEEN)) begin
            line_ff <= csr_write_data;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/jtl_out_buf.sv
// ============================================================================
// jtl_out_buf: result buffer
// Holds the up to three results of one input word and hands them out one
// word per cycle while rsp_ready is high; marks the final one of each run.
// ============================================================================
`default_nettype none

module jtl_out_buf
   import jtl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load_en,
   input  wire jtl_load_type load,
   output logic              can_load,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output jtl_rsp_type       rsp_data
);

   jtl_rsp_type [MAX_RESULTS-1:0] slot_ff, slot_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] rem_ff, rem_in;
   logic       pop;

   assign rsp_valid = (rem_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   // Room for a new run once the last held word leaves
   assign can_load  = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && pop);

   always_comb begin
      rsp_data             = slot_ff[idx_ff];
      rsp_data.last_of_run = (rem_ff == 2'd1);
   end

   // Next buffer state
   always_comb begin
      slot_in = slot_ff;
      idx_in  = idx_ff;
      rem_in  = rem_ff;
      if (pop) begin
         idx_in = idx_ff + 2'd1;
         rem_in = rem_ff - 2'd1;
      end
      if (load_en && (load.count != 2'd0)) begin
         slot_in = load.slot;
         idx_in  = 2'd0;
         rem_in  = load.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         rem_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         rem_ff <= rem_in;
      end
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

### rtl/json_token_lexer_unit.sv
// ============================================================================
// json_token_lexer_unit: byte-serial JSON lexer
// Turns a stream of text bytes into punctuation, string, bare and end tokens
// with line, column, offset and length.
// ============================================================================
// One byte word enters per cycle while req_ready is high. It is held in an
// input register, lexed by combinational logic in the core and its results
// (none to three) are loaded into a result buffer that drives rsp_*, where
// they are offered. The output hands out one result word per cycle while
// rsp_ready is high; after a byte with several results the next byte waits
// in the input register until the last one is taken, and bytes causing at
// most one result flow at one per cycle. csr_write_data sets the number of
// the first line of each buffer; it also applies at once if the current
// buffer has not taken a byte yet and no word is being lexed.
`default_nettype none

module json_token_lexer_unit
   import jtl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire jtl_req_type          req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output jtl_rsp_type               rsp_data,
   input  wire logic                 csr_write_en,
   input  wire logic [LINE_BITS-1:0] csr_write_data
);

   logic         in_valid_ff, in_valid_in;
   jtl_req_type  in_item_ff;
   logic         can_load;
   logic         fire;
   logic         accept;
   jtl_load_type load;

   // Input register handshake
   assign fire        = in_valid_ff && can_load;
   assign req_ready   = !in_valid_ff || fire;
   assign accept      = req_valid && req_ready;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_item_ff <= req_data;
      end
   end

   jtl_core u_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .item           (in_item_ff),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .load           (load)
   );

   jtl_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load_en   (fire),
      .load      (load),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
